// ===== hdl/msp_pkg.sv =====
// Package for the memory size text parser: phase and suffix codes,
// character constants, suffix matcher and unit scale table.
// No dependencies.
package msp_pkg;

   localparam int CHAR_W  = 8;
   localparam int VALUE_W = 64;
   localparam int PHASE_W = 3;
   localparam int SX_W    = 4;
   localparam int DIGIT_W = 4;
   localparam int SCALE_W = 31;
   localparam int HALF_W  = VALUE_W / 2;

   typedef logic [CHAR_W-1:0]  char_type;
   typedef logic [VALUE_W-1:0] value_type;
   typedef logic [PHASE_W-1:0] phase_type;
   typedef logic [SX_W-1:0]    sx_type;
   typedef logic [SCALE_W-1:0] scale_type;

   // parse phases
   localparam phase_type PH_SPACE  = 3'd0;
   localparam phase_type PH_SIGN   = 3'd1;
   localparam phase_type PH_DIGITS = 3'd2;
   localparam phase_type PH_SUFFIX = 3'd3;
   localparam phase_type PH_FAIL   = 3'd4;
   localparam phase_type PH_ENDED  = 3'd5;

   // suffix match progress
   localparam sx_type SX_NONE = 4'd0;
   localparam sx_type SX_K    = 4'd1;
   localparam sx_type SX_M    = 4'd2;
   localparam sx_type SX_G    = 4'd3;
   localparam sx_type SX_KI   = 4'd4;
   localparam sx_type SX_MI   = 4'd5;
   localparam sx_type SX_GI   = 4'd6;
   localparam sx_type SX_KB   = 4'd7;
   localparam sx_type SX_MB   = 4'd8;
   localparam sx_type SX_GB   = 4'd9;
   localparam sx_type SX_KIB  = 4'd10;
   localparam sx_type SX_MIB  = 4'd11;
   localparam sx_type SX_GIB  = 4'd12;
   localparam sx_type SX_BAD  = 4'd15;

   // distance from a one-letter code to its "i" and "b" successors
   localparam sx_type SX_STEP_I = 4'd3;
   localparam sx_type SX_STEP_B = 4'd6;

   localparam char_type CH_NUL   = 8'h00;
   localparam char_type CH_TAB   = 8'h09;
   localparam char_type CH_CR    = 8'h0D;
   localparam char_type CH_SPACE = 8'h20;
   localparam char_type CH_PLUS  = 8'h2B;
   localparam char_type CH_MINUS = 8'h2D;
   localparam char_type CH_ZERO  = 8'h30;
   localparam char_type CH_NINE  = 8'h39;
   localparam char_type CH_UC_A  = 8'h41;
   localparam char_type CH_UC_Z  = 8'h5A;
   localparam char_type CH_CASE  = 8'h20;
   localparam char_type CH_B     = 8'h62;
   localparam char_type CH_G     = 8'h67;
   localparam char_type CH_I     = 8'h69;
   localparam char_type CH_K     = 8'h6B;
   localparam char_type CH_M     = 8'h6D;

   // largest accumulator that can still take a digit, and the digit limit there
   localparam value_type ACC_CUTOFF = 64'h1999_9999_9999_9999;
   localparam logic [DIGIT_W-1:0] ACC_CUTLIM = 4'd5;

   function automatic sx_type suffix_next(input sx_type code, input char_type c);
      char_type lc;
      sx_type   nx;
      lc = c;
      if (c inside {[CH_UC_A:CH_UC_Z]}) begin
         lc = c + CH_CASE;
      end
      nx = SX_BAD;
      if (code == SX_NONE) begin
         if (lc == CH_K) begin
            nx = SX_K;
         end else if (lc == CH_M) begin
            nx = SX_M;
         end else if (lc == CH_G) begin
            nx = SX_G;
         end
      end else if (code inside {SX_K, SX_M, SX_G}) begin
         if (lc == CH_I) begin
            nx = code + SX_STEP_I;
         end else if (lc == CH_B) begin
            nx = code + SX_STEP_B;
         end
      end else if (code inside {SX_KI, SX_MI, SX_GI}) begin
         if (lc == CH_B) begin
            nx = code + SX_STEP_B;
         end
      end
      return nx;
   endfunction

   function automatic logic suffix_final(input sx_type code);
      return code inside {SX_NONE, [SX_KB:SX_GIB]};
   endfunction

   function automatic scale_type scale_of(input sx_type code);
      scale_type s;
      case (code)
         SX_NONE: s = 31'd1;
         SX_KB:   s = 31'd1000;
         SX_MB:   s = 31'd1000000;
         SX_GB:   s = 31'd1000000000;
         SX_KIB:  s = 31'd1024;
         SX_MIB:  s = 31'd1048576;
         SX_GIB:  s = 31'd1073741824;
         default: s = '0;
      endcase
      return s;
   endfunction

endpackage

// ===== hdl/memory_size_text_parser.sv =====
// Memory size text parser top level: character parse state, value
// pipeline and result register. Depends on msp_pkg.
//
// Channel  Dir  Ports                                   Transfer
// req      in   req_char_in[7:0], req_last              req_valid & req_ready
// rsp      out  rsp_size_value[63:0], rsp_ok            rsp_valid & rsp_ready
//
// One character per cycle while req_ready is high; the parse state is updated
// on every req transfer. After the transfer of the last character, a result
// passes through stage 1 capture, sign/saturate, split multiply and final add
// into the result register, where rsp_valid is high.
// Each stage holds only while the stage after it is full and stalled, so input
// keeps flowing while a finished result waits on rsp_ready, until stages fill.
// Synchronous active-high reset clears the parse state and all valid bits.
module memory_size_text_parser (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  msp_pkg::char_type     req_char_in,
   input  logic                  req_last,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output msp_pkg::value_type    rsp_size_value,
   output logic                  rsp_ok
);
   import msp_pkg::*;

   // ---------------------------------------------------------------
   // Parse state
   // ---------------------------------------------------------------
   phase_type phase_ff, phase_in;
   value_type acc_ff, acc_in;
   logic      ovf_ff, ovf_in;
   logic      neg_ff, neg_in;
   sx_type    sx_ff, sx_in;

   // pipeline stages
   logic      s1_v_ff, s2_v_ff, s3_v_ff, rsp_valid_ff;
   value_type s1_acc_ff;
   logic      s1_ovf_ff, s1_neg_ff, s1_good_ff;
   sx_type    s1_sx_ff;
   value_type s2_val_ff;
   scale_type s2_scale_ff;
   logic      s2_ok_ff;
   logic [HALF_W+SCALE_W-1:0] s3_lo_ff;
   logic [HALF_W-1:0]         s3_hi_ff;
   logic      s3_ok_ff;
   value_type rsp_size_value_ff;
   logic      rsp_ok_ff;

   logic      out_ready, s3_ready, s2_ready, s1_ready;
   logic      req_xfer;
   logic      is_digit, is_space;
   logic [DIGIT_W-1:0] digit;
   value_type acc_mac;
   logic      acc_over;
   logic      good_in;
   sx_type    sx_try;
   value_type s2_val_in;
   logic [HALF_W+SCALE_W-1:0] prod_lo;
   logic [HALF_W-1:0]         prod_hi;

   // a stage may load when it is empty or its content moves on this cycle
   assign out_ready = !rsp_valid_ff || rsp_ready;
   assign s3_ready  = !s3_v_ff || out_ready;
   assign s2_ready  = !s2_v_ff || s3_ready;
   assign s1_ready  = !s1_v_ff || s2_ready;
   assign req_ready = s1_ready;
   assign req_xfer  = req_valid && req_ready;

   assign is_digit = req_char_in inside {[CH_ZERO:CH_NINE]};
   assign is_space = (req_char_in == CH_SPACE) || (req_char_in inside {[CH_TAB:CH_CR]});
   assign digit    = DIGIT_W'(req_char_in - CH_ZERO);

   // acc * 10 + digit, and the strtoul-style overflow test
   assign acc_mac  = (acc_ff << 3) + (acc_ff << 1) + VALUE_W'(digit);
   assign acc_over = (acc_ff > ACC_CUTOFF) || ((acc_ff == ACC_CUTOFF) && (digit > ACC_CUTLIM));
   assign sx_try   = suffix_next(sx_ff, req_char_in);

   always_comb begin
      phase_in = phase_ff;
      acc_in   = acc_ff;
      ovf_in   = ovf_ff;
      neg_in   = neg_ff;
      sx_in    = sx_ff;
      case (phase_ff)
         PH_SPACE: begin
            if (is_space) begin
               phase_in = PH_SPACE;
            end else if (req_char_in == CH_PLUS || req_char_in == CH_MINUS) begin
               neg_in   = (req_char_in == CH_MINUS);
               phase_in = PH_SIGN;
            end else if (is_digit) begin
               phase_in = PH_DIGITS;
            end else begin
               phase_in = PH_FAIL;
            end
         end
         PH_SIGN: begin
            phase_in = is_digit ? PH_DIGITS : PH_FAIL;
         end
         PH_DIGITS, PH_SUFFIX: begin
            if (is_digit && phase_ff == PH_DIGITS) begin
               phase_in = PH_DIGITS;
            end else if (req_char_in == CH_NUL) begin
               phase_in = PH_ENDED;
            end else if (sx_try == SX_BAD) begin
               phase_in = PH_FAIL;
            end else begin
               sx_in    = sx_try;
               phase_in = PH_SUFFIX;
            end
         end
         PH_ENDED: begin
            phase_in = PH_ENDED;
         end
         default: begin
            phase_in = PH_FAIL;
         end
      endcase
      // digit accumulation, shared by the three phases that take digits
      if (is_digit && (phase_ff == PH_SPACE || phase_ff == PH_SIGN || phase_ff == PH_DIGITS)
          && !ovf_ff) begin
         if (acc_over) begin
            ovf_in = 1'b1;
         end else begin
            acc_in = acc_mac;
         end
      end
   end

   assign good_in = (phase_in == PH_DIGITS || phase_in == PH_SUFFIX || phase_in == PH_ENDED)
                    && suffix_final(sx_in);

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_SPACE;
         acc_ff   <= '0;
         ovf_ff   <= 1'b0;
         neg_ff   <= 1'b0;
         sx_ff    <= SX_NONE;
      end else if (req_xfer) begin
         if (req_last) begin
            // string done: back to the start state for the next one
            phase_ff <= PH_SPACE;
            acc_ff   <= '0;
            ovf_ff   <= 1'b0;
            neg_ff   <= 1'b0;
            sx_ff    <= SX_NONE;
         end else begin
            phase_ff <= phase_in;
            acc_ff   <= acc_in;
            ovf_ff   <= ovf_in;
            neg_ff   <= neg_in;
            sx_ff    <= sx_in;
         end
      end
   end

   // ---------------------------------------------------------------
   // Stage 1: final parse state of a finished string
   // ---------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (s1_ready) begin
         s1_acc_ff  <= acc_in;
         s1_ovf_ff  <= ovf_in;
         s1_neg_ff  <= neg_in;
         s1_good_ff <= good_in;
         s1_sx_ff   <= sx_in;
      end
   end

   // ---------------------------------------------------------------
   // Stage 2: saturate or negate; pick unit scale. Failed strings give 0.
   // ---------------------------------------------------------------
   always_comb begin
      if (!s1_good_ff) begin
         s2_val_in = '0;
      end else if (s1_ovf_ff) begin
         s2_val_in = '1;
      end else if (s1_neg_ff) begin
         s2_val_in = '0 - s1_acc_ff;
      end else begin
         s2_val_in = s1_acc_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s2_ready) begin
         s2_val_ff   <= s2_val_in;
         s2_scale_ff <= scale_of(s1_sx_ff);
         s2_ok_ff    <= s1_good_ff;
      end
   end

   // ---------------------------------------------------------------
   // Stage 3: value * scale as two 32 x 31 partial products; only the
   // low half of the upper product survives mod 2^64
   // ---------------------------------------------------------------
   assign prod_lo = (HALF_W+SCALE_W)'(s2_val_ff[HALF_W-1:0])
                    * (HALF_W+SCALE_W)'(s2_scale_ff);
   assign prod_hi = s2_val_ff[VALUE_W-1:HALF_W] * HALF_W'(s2_scale_ff);

   always_ff @(posedge clock) begin
      if (s3_ready) begin
         s3_lo_ff <= prod_lo;
         s3_hi_ff <= prod_hi;
         s3_ok_ff <= s2_ok_ff;
      end
   end

   // ---------------------------------------------------------------
   // Result register: combine partial products
   // ---------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (out_ready) begin
         rsp_size_value_ff <= VALUE_W'(s3_lo_ff) + {s3_hi_ff, {HALF_W{1'b0}}};
         rsp_ok_ff         <= s3_ok_ff;
      end
   end

   // valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff      <= 1'b0;
         s2_v_ff      <= 1'b0;
         s3_v_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (s1_ready) begin
            s1_v_ff <= req_valid && req_last;
         end
         if (s2_ready) begin
            s2_v_ff <= s1_v_ff;
         end
         if (s3_ready) begin
            s3_v_ff <= s2_v_ff;
         end
         if (out_ready) begin
            rsp_valid_ff <= s3_v_ff;
         end
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_size_value = rsp_size_value_ff;
   assign rsp_ok         = rsp_ok_ff;

`ifndef NO_ASSERTIONS
   // a rejected string always reports a zero size
   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ok |-> rsp_size_value == '0)
      else $error("failed parse with nonzero size");

   // the last character returns the parser to its start state
   a_restart: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_last |=>
         phase_ff == PH_SPACE && sx_ff == SX_NONE && acc_ff == '0 && !ovf_ff && !neg_ff)
      else $error("parse state not cleared after last character");

   // a new result enters the pipeline only from a last-character transfer
   a_s1_source: assert property (@(posedge clock) disable iff (reset)
      $rose(s1_v_ff) |-> $past(req_valid && req_ready && req_last))
      else $error("stage 1 valid without last-character transfer");
`endif

endmodule
